// ----- src/rvdec_pkg.sv -----
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types, opcodes, operation numbers and lookup functions for the
// RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam int unsigned InstrW  = 32;
  localparam int unsigned OpKindW = 6;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned ImmW    = 32;
  localparam int unsigned OutDataW = 56;   // 53 field bits, padded to whole bytes

  // major opcodes
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MUL  = 7'b0000001;

  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SR  = 3'd5;
  localparam logic [2:0] F3_ADD = 3'd0;

  // operation numbers
  localparam logic [OpKindW-1:0] OP_LB     = 6'd0;
  localparam logic [OpKindW-1:0] OP_LH     = 6'd1;
  localparam logic [OpKindW-1:0] OP_LW     = 6'd2;
  localparam logic [OpKindW-1:0] OP_LBU    = 6'd3;
  localparam logic [OpKindW-1:0] OP_LHU    = 6'd4;
  localparam logic [OpKindW-1:0] OP_ADDI   = 6'd5;
  localparam logic [OpKindW-1:0] OP_SLLI   = 6'd6;
  localparam logic [OpKindW-1:0] OP_SLTI   = 6'd7;
  localparam logic [OpKindW-1:0] OP_SLTIU  = 6'd8;
  localparam logic [OpKindW-1:0] OP_XORI   = 6'd9;
  localparam logic [OpKindW-1:0] OP_SRLI   = 6'd10;
  localparam logic [OpKindW-1:0] OP_SRAI   = 6'd11;
  localparam logic [OpKindW-1:0] OP_ORI    = 6'd12;
  localparam logic [OpKindW-1:0] OP_ANDI   = 6'd13;
  localparam logic [OpKindW-1:0] OP_AUIPC  = 6'd14;
  localparam logic [OpKindW-1:0] OP_SB     = 6'd15;
  localparam logic [OpKindW-1:0] OP_SH     = 6'd16;
  localparam logic [OpKindW-1:0] OP_SW     = 6'd17;
  localparam logic [OpKindW-1:0] OP_ADD    = 6'd18;
  localparam logic [OpKindW-1:0] OP_SUB    = 6'd19;
  localparam logic [OpKindW-1:0] OP_MUL    = 6'd20;
  localparam logic [OpKindW-1:0] OP_SLL    = 6'd21;
  localparam logic [OpKindW-1:0] OP_MULH   = 6'd22;
  localparam logic [OpKindW-1:0] OP_SLT    = 6'd23;
  localparam logic [OpKindW-1:0] OP_MULHSU = 6'd24;
  localparam logic [OpKindW-1:0] OP_SLTU   = 6'd25;
  localparam logic [OpKindW-1:0] OP_MULHU  = 6'd26;
  localparam logic [OpKindW-1:0] OP_XOR    = 6'd27;
  localparam logic [OpKindW-1:0] OP_DIV    = 6'd28;
  localparam logic [OpKindW-1:0] OP_SRL    = 6'd29;
  localparam logic [OpKindW-1:0] OP_SRA    = 6'd30;
  localparam logic [OpKindW-1:0] OP_DIVU   = 6'd31;
  localparam logic [OpKindW-1:0] OP_OR     = 6'd32;
  localparam logic [OpKindW-1:0] OP_REM    = 6'd33;
  localparam logic [OpKindW-1:0] OP_AND    = 6'd34;
  localparam logic [OpKindW-1:0] OP_REMU   = 6'd35;
  localparam logic [OpKindW-1:0] OP_LUI    = 6'd36;
  localparam logic [OpKindW-1:0] OP_BEQ    = 6'd37;
  localparam logic [OpKindW-1:0] OP_BNE    = 6'd38;
  localparam logic [OpKindW-1:0] OP_BLT    = 6'd39;
  localparam logic [OpKindW-1:0] OP_BGE    = 6'd40;
  localparam logic [OpKindW-1:0] OP_BLTU   = 6'd41;
  localparam logic [OpKindW-1:0] OP_BGEU   = 6'd42;
  localparam logic [OpKindW-1:0] OP_JALR   = 6'd43;
  localparam logic [OpKindW-1:0] OP_JAL    = 6'd44;
  localparam logic [OpKindW-1:0] OP_LAST   = OP_JAL;

  // decode of one word
  typedef struct packed {
    logic [OpKindW-1:0] op_kind;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src_reg_a;
    logic [RegIdxW-1:0] src_reg_b;
    logic [ImmW-1:0]    immediate;
    logic               illegal;
  } rvdec_result_t;

  // lookup with a valid flag in the top bit
  typedef struct packed {
    logic               ok;
    logic [OpKindW-1:0] kind;
  } rvdec_kind_t;

  function automatic rvdec_kind_t load_kind(input logic [2:0] f3);
    rvdec_kind_t k;
    k = '{ok: 1'b1, kind: OP_LB};
    case (f3)
      3'd0: k.kind = OP_LB;
      3'd1: k.kind = OP_LH;
      3'd2: k.kind = OP_LW;
      3'd4: k.kind = OP_LBU;
      3'd5: k.kind = OP_LHU;
      default: k.ok = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [OpKindW-1:0] opimm_kind(input logic [2:0] f3);
    logic [OpKindW-1:0] k;
    case (f3)
      3'd0: k = OP_ADDI;
      3'd1: k = OP_SLLI;
      3'd2: k = OP_SLTI;
      3'd3: k = OP_SLTIU;
      3'd4: k = OP_XORI;
      3'd5: k = OP_SRLI;
      3'd6: k = OP_ORI;
      default: k = OP_ANDI;
    endcase
    return k;
  endfunction

  function automatic logic [OpKindW-1:0] op_base_kind(input logic [2:0] f3);
    logic [OpKindW-1:0] k;
    case (f3)
      3'd0: k = OP_ADD;
      3'd1: k = OP_SLL;
      3'd2: k = OP_SLT;
      3'd3: k = OP_SLTU;
      3'd4: k = OP_XOR;
      3'd5: k = OP_SRL;
      3'd6: k = OP_OR;
      default: k = OP_AND;
    endcase
    return k;
  endfunction

  function automatic logic [OpKindW-1:0] op_mul_kind(input logic [2:0] f3);
    logic [OpKindW-1:0] k;
    case (f3)
      3'd0: k = OP_MUL;
      3'd1: k = OP_MULH;
      3'd2: k = OP_MULHSU;
      3'd3: k = OP_MULHU;
      3'd4: k = OP_DIV;
      3'd5: k = OP_DIVU;
      3'd6: k = OP_REM;
      default: k = OP_REMU;
    endcase
    return k;
  endfunction

  function automatic rvdec_kind_t branch_kind(input logic [2:0] f3);
    rvdec_kind_t k;
    k = '{ok: 1'b1, kind: OP_BEQ};
    case (f3)
      3'd0: k.kind = OP_BEQ;
      3'd1: k.kind = OP_BNE;
      3'd4: k.kind = OP_BLT;
      3'd5: k.kind = OP_BGE;
      3'd6: k.kind = OP_BLTU;
      3'd7: k.kind = OP_BGEU;
      default: k.ok = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ----- src/rvdec_decode.sv -----
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational decode of one RV32IM word: operation number, register
// fields, format immediate and illegal flag.
// ----------------------------------------------------------------------------
module rvdec_decode (
  input  logic [rvdec_pkg::InstrW-1:0] instr,
  output rvdec_pkg::rvdec_result_t     result
);

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] shamt;
  logic [31:0] imm;
  logic [rvdec_pkg::OpKindW-1:0] kind;
  logic        ok;
  rvdec_pkg::rvdec_kind_t lk;
  rvdec_pkg::rvdec_kind_t bk;

  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign imm_u = {instr[31:12], 12'b0};
  assign shamt = {27'b0, instr[24:20]};

  assign lk = rvdec_pkg::load_kind(f3);
  assign bk = rvdec_pkg::branch_kind(f3);

  always_comb begin
    kind = rvdec_pkg::OP_LB;
    ok   = 1'b0;
    imm  = '0;
    case (opc)
      rvdec_pkg::OPC_LOAD: begin
        kind = lk.kind;
        ok   = lk.ok;
        imm  = imm_i;
      end
      rvdec_pkg::OPC_OPIMM: begin
        kind = rvdec_pkg::opimm_kind(f3);
        ok   = 1'b1;
        imm  = imm_i;
        if (f3 == rvdec_pkg::F3_SLL) begin
          imm = shamt;
          ok  = (f7 == rvdec_pkg::F7_BASE);
        end else if (f3 == rvdec_pkg::F3_SR) begin
          imm = shamt;
          // only bit 30 picks arithmetic shift
          if (instr[30]) begin
            kind = rvdec_pkg::OP_SRAI;
          end
        end
      end
      rvdec_pkg::OPC_AUIPC: begin
        kind = rvdec_pkg::OP_AUIPC;
        ok   = 1'b1;
        imm  = imm_u;
      end
      rvdec_pkg::OPC_STORE: begin
        kind = rvdec_pkg::OP_SB + {3'b0, f3};
        ok   = (f3 < 3'd3);
        imm  = imm_s;
      end
      rvdec_pkg::OPC_OP: begin
        if (f7 == rvdec_pkg::F7_BASE) begin
          kind = rvdec_pkg::op_base_kind(f3);
          ok   = 1'b1;
        end else if (f7 == rvdec_pkg::F7_MUL) begin
          kind = rvdec_pkg::op_mul_kind(f3);
          ok   = 1'b1;
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_ADD) begin
          kind = rvdec_pkg::OP_SUB;
          ok   = 1'b1;
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == rvdec_pkg::F3_SR) begin
          kind = rvdec_pkg::OP_SRA;
          ok   = 1'b1;
        end
      end
      rvdec_pkg::OPC_LUI: begin
        kind = rvdec_pkg::OP_LUI;
        ok   = 1'b1;
        imm  = imm_u;
      end
      rvdec_pkg::OPC_BRANCH: begin
        kind = bk.kind;
        ok   = bk.ok;
        imm  = imm_b;
      end
      rvdec_pkg::OPC_JALR: begin
        kind = rvdec_pkg::OP_JALR;
        ok   = (f3 == 3'd0);
        imm  = imm_i;
      end
      rvdec_pkg::OPC_JAL: begin
        kind = rvdec_pkg::OP_JAL;
        ok   = 1'b1;
        imm  = imm_j;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.op_kind   = ok ? kind : '0;
    result.dest_reg  = instr[11:7];
    result.src_reg_a = instr[19:15];
    result.src_reg_b = instr[24:20];
    result.immediate = ok ? imm : '0;
    result.illegal   = ~ok;
  end

endmodule

// ----- src/rv32im_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// Streaming RV32IM decoder: input word register, decode logic, result
// register.
// ----------------------------------------------------------------------------
// One instruction word is taken per cycle while in_tready is high. A word
// accepted into the input register is decoded into the result register once
// that register is empty or being handed off, which raises out_tvalid; the
// decode leaves from the result register. Under back-pressure both stages
// hold, and in_tready drops only when both are full and out_tready is
// low. The result carries the operation number, rd/rs1/rs2 fields and the
// format immediate in out_tdata, and the illegal flag in out_tuser; an
// illegal word gives operation 0 and immediate 0. Nothing is stored between
// words, so latency and rate do not depend on the instruction.
module rv32im_instruction_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] instr_word
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] op_kind, [10:6] dest_reg, [15:11] src_reg_a, [20:16] src_reg_b,
  // [52:21] immediate, [55:53] zero
  output logic [rvdec_pkg::OutDataW-1:0] out_tdata,
  output logic        out_tuser   // [0] illegal
);

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] s1_word_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  rvdec_pkg::rvdec_result_t out_res_r;
  rvdec_pkg::rvdec_result_t dec_res;
  logic        s2_load;
  logic        s1_load;

  rvdec_decode u_decode (
    .instr  (s1_word_r),
    .result (dec_res)
  );

  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_tdata;
    end
    if (s2_load) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.immediate, out_res_r.src_reg_b,
                       out_res_r.src_reg_a, out_res_r.dest_reg, out_res_r.op_kind};
  assign out_tuser  = out_res_r.illegal;

`ifndef SYNTH
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[5:0] == 6'd0 && out_tdata[52:21] == 32'd0))
    else $error("illegal result with nonzero op or immediate");

  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= rvdec_pkg::OP_LAST))
    else $error("operation number out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("pipeline not empty after reset");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !s1_valid_r) |=> !out_tvalid)
    else $error("result repeated after hand-off");
`endif

endmodule
